[hdl/ganv_pkg.sv]
// Package for the gap-aware noise variance unit.
// Holds widths, the shared arithmetic unit's operation codes, register indices and handshake types.
// No dependencies.
package ganv_pkg;

    localparam int MAX_SAMPLES = 1048576;
    localparam int COUNT_W     = 21;
    localparam int SUM_W       = 37;
    localparam int SQSUM_W     = 53;
    localparam int DTOT_W      = 38;
    localparam int WIDE_W      = 74;
    localparam int DIVR_W      = 42;
    localparam int QUOT_W      = 34;
    localparam int ITER_W      = 7;
    localparam int MUL_ITERS   = 42;
    localparam int DIV_ITERS   = 74;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    localparam logic [1:0] REG_MAX_GAP  = 2'd0;
    localparam logic [1:0] REG_MIN_DIFF = 2'd1;
    localparam logic [1:0] REG_AUTO_THR = 2'd2;

    typedef struct packed {
        logic start;
        logic op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } arith_rsp_t;

endpackage

[hdl/ganv_arith.sv]
// Shared iterative arithmetic unit: shift-add multiply and restoring divide.
// One bit per cycle; depends on ganv_pkg.
module ganv_arith
    import ganv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  arith_req_t            req,
    input  logic [WIDE_W-1:0]     opa,
    input  logic [DIVR_W-1:0]     opb,
    output arith_rsp_t            rsp,
    output logic [WIDE_W-1:0]     product,
    output logic [QUOT_W-1:0]     quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic              op_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [WIDE_W-1:0] a_reg;
    logic [DIVR_W-1:0] b_reg;
    logic [WIDE_W-1:0] acc_reg;
    logic [DIVR_W:0]   rem_reg;
    logic [QUOT_W-1:0] q_reg;
    logic              ovf_reg;

    logic [DIVR_W:0]   rem_shift;
    logic              fits;
    logic [ITER_W-1:0] iter_last;

    // One divide step: bring down the next dividend bit and try the divisor
    assign rem_shift = {rem_reg[DIVR_W-1:0], a_reg[WIDE_W-1]};
    assign fits      = rem_shift >= {1'b0, b_reg};
    assign iter_last = (op_reg == OP_DIV) ? ITER_W'(DIV_ITERS - 1) : ITER_W'(MUL_ITERS - 1);

    // Control: count iterations, flag completion for one cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && iter_reg == iter_last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: load operands, then one multiply or divide step a cycle
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            op_reg   <= req.op;
            iter_reg <= '0;
            a_reg    <= opa;
            b_reg    <= opb;
            acc_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (op_reg == OP_MUL) begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= {a_reg[WIDE_W-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[DIVR_W-1:1]};
            end else begin
                a_reg   <= {a_reg[WIDE_W-2:0], 1'b0};
                rem_reg <= fits ? rem_shift - {1'b0, b_reg} : rem_shift;
                q_reg   <= {q_reg[QUOT_W-2:0], fits};
                ovf_reg <= ovf_reg | q_reg[QUOT_W-1];
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign product  = acc_reg;
    assign quotient = q_reg;

endmodule

[hdl/gap_aware_noise_variance_unit.sv]
// Gap-aware lag-1 noise variance unit: one sample a transaction, a result on tlast.
// An accepted sample is registered, squared and accumulated in turn; the block is not
// ready meanwhile. On the last sample a sequencer runs nine operations through one shared
// bit-serial unit, six multiplies and three divides, after which m_tvalid rises once the
// output register is free. The auto threshold count/20 comes from a reciprocal multiply.
// A finished result waits in the output register while the next series is taken in.
// Depends on ganv_pkg and ganv_arith.
module gap_aware_noise_variance_unit
    import ganv_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    // APB-style configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // Sample stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // sample [15:0], position [46:16], zero pad
    input  logic          s_tlast,
    // Result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // mean [15:0], total var [47:16],
                                     // noise var [80:48], diff count [100:81], pad
    output logic [1:0]    m_tuser    // stats_valid [0], noise_valid [1]
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_ISSUE = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [3:0] STEP_LAST = 4'd8;

    // ceil(2^25 / 20): exact floor(count / 20) for every count up to 2^22
    localparam logic [20:0] THR_RECIP = 21'd1677722;

    // Configuration registers
    logic [15:0] max_gap_reg;
    logic [19:0] min_diff_reg;
    logic        auto_thr_reg;

    // Series state
    logic [COUNT_W-1:0]        count_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [SQSUM_W-1:0]        sqsum_reg;
    logic [15:0]               prev_sample_reg;
    logic [30:0]               prev_pos_reg;
    logic signed [DTOT_W-1:0]  dtot_reg;
    logic [SQSUM_W-1:0]        dsqsum_reg;
    logic [COUNT_W-1:0]        nd_reg;

    // Item pipeline
    logic [2:0]   state_reg;
    logic [15:0]  in_sample_reg;
    logic [30:0]  in_pos_reg;
    logic         in_last_reg;
    logic [31:0]  sq_reg;
    logic [33:0]  dsq_reg;
    logic signed [16:0] d_reg;
    logic         take_reg;
    logic         pair_reg;

    // Final computation
    logic [3:0]          step_reg;
    logic [WIDE_W-1:0]   p_reg;
    logic [WIDE_W-1:0]   num_reg;
    logic [DIVR_W-1:0]   den_reg;
    logic [31:0]         var_reg;
    logic [32:0]         noise_reg;
    logic [15:0]         mean_reg;
    logic [COUNT_W-1:0]  thr_auto_reg;

    // Output register
    logic          m_tvalid_reg;
    logic [103:0]  m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    arith_req_t         areq;
    arith_rsp_t         arsp;
    logic [WIDE_W-1:0]  opa;
    logic [DIVR_W-1:0]  opb;
    logic [WIDE_W-1:0]  product;
    logic [QUOT_W-1:0]  quotient;

    logic               cfg_wr;
    logic signed [32:0] pos_delta;
    logic signed [32:0] gap_limit;
    logic signed [16:0] d_now;
    logic [DTOT_W-1:0]  dtot_abs;
    logic [SUM_W-1:0]   absd;
    logic [WIDE_W:0]    num_diff;
    logic [41:0]        thr_prod;
    logic [COUNT_W-1:0] thr;
    logic               sv;
    logic               nv;
    logic               out_free;

    // Configuration writes and reads
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg  <= 16'd0;
            min_diff_reg <= 20'd16;
            auto_thr_reg <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MAX_GAP:  max_gap_reg  <= pwdata[15:0];
                REG_MIN_DIFF: min_diff_reg <= pwdata[19:0];
                REG_AUTO_THR: auto_thr_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_GAP:  prdata = {16'd0, max_gap_reg};
            REG_MIN_DIFF: prdata = {12'd0, min_diff_reg};
            REG_AUTO_THR: prdata = {31'd0, auto_thr_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // Gap test and lag-1 difference of the held sample
    assign pos_delta = $signed({2'b00, in_pos_reg}) - $signed({2'b00, prev_pos_reg});
    assign gap_limit = $signed({16'd0, {1'b0, max_gap_reg} + 17'd1});
    assign d_now     = $signed({1'b0, in_sample_reg}) - $signed({1'b0, prev_sample_reg});

    // Operands of the shared unit per step
    assign dtot_abs = dtot_reg[DTOT_W-1] ? DTOT_W'(-dtot_reg) : DTOT_W'(dtot_reg);
    assign absd     = dtot_abs[SUM_W-1:0];

    always_comb begin
        areq.start = (state_reg == ST_ISSUE);
        areq.op    = OP_MUL;
        opa        = '0;
        opb        = '0;
        case (step_reg)
            4'd0: begin
                opa = WIDE_W'(sqsum_reg);
                opb = DIVR_W'(count_reg);
            end
            4'd1: begin
                opa = WIDE_W'(sum_reg);
                opb = DIVR_W'(sum_reg);
            end
            4'd2: begin
                opa = WIDE_W'(count_reg);
                opb = DIVR_W'(count_reg - 1'b1);
            end
            4'd3: begin
                areq.op = OP_DIV;
                opa     = num_reg;
                opb     = den_reg;
            end
            4'd4: begin
                opa = WIDE_W'(dsqsum_reg);
                opb = DIVR_W'(nd_reg);
            end
            4'd5: begin
                opa = WIDE_W'(absd);
                opb = DIVR_W'(absd);
            end
            4'd6: begin
                opa = WIDE_W'(nd_reg);
                opb = DIVR_W'(nd_reg - 1'b1);
            end
            4'd7: begin
                areq.op = OP_DIV;
                opa     = num_reg;
                opb     = den_reg;
            end
            4'd8: begin
                areq.op = OP_DIV;
                opa     = WIDE_W'(sum_reg);
                opb     = DIVR_W'(count_reg);
            end
            default: ;
        endcase
    end

    ganv_arith u_arith (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (areq),
        .opa      (opa),
        .opb      (opb),
        .rsp      (arsp),
        .product  (product),
        .quotient (quotient)
    );

    // Numerator: first product minus second, clamped at zero
    assign num_diff = {1'b0, p_reg} - {1'b0, product};

    // Auto threshold base: count / 20 by reciprocal multiply
    assign thr_prod = {21'd0, count_reg} * {21'd0, THR_RECIP};

    // Validity and threshold
    assign thr = auto_thr_reg ? ((thr_auto_reg > COUNT_W'(16)) ? thr_auto_reg : COUNT_W'(16))
                              : COUNT_W'(min_diff_reg);
    assign sv  = count_reg >= COUNT_W'(2);
    assign nv  = (nd_reg >= thr) && (nd_reg >= COUNT_W'(2));

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: state_reg <= ST_ACC;
                ST_ACC: begin
                    step_reg  <= 4'd0;
                    state_reg <= in_last_reg ? ST_ISSUE : ST_IDLE;
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (arsp.done) begin
                        if (step_reg == STEP_LAST) begin
                            state_reg <= ST_OUT;
                        end else begin
                            step_reg  <= step_reg + 4'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Capture the transaction, square, then accumulate
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            in_sample_reg <= s_tdata[15:0];
            in_pos_reg    <= s_tdata[46:16];
            in_last_reg   <= s_tlast;
        end
        if (state_reg == ST_SQ) begin
            sq_reg   <= in_sample_reg * in_sample_reg;
            dsq_reg  <= 34'(d_now * d_now);
            d_reg    <= d_now;
            take_reg <= count_reg < COUNT_W'(MAX_SAMPLES);
            pair_reg <= (count_reg != '0) && (pos_delta <= gap_limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            sum_reg         <= '0;
            sqsum_reg       <= '0;
            prev_sample_reg <= '0;
            prev_pos_reg    <= '0;
            dtot_reg        <= '0;
            dsqsum_reg      <= '0;
            nd_reg          <= '0;
        end else if (state_reg == ST_ACC && take_reg) begin
            count_reg       <= count_reg + 1'b1;
            sum_reg         <= sum_reg + SUM_W'(in_sample_reg);
            sqsum_reg       <= sqsum_reg + SQSUM_W'(sq_reg);
            prev_sample_reg <= in_sample_reg;
            prev_pos_reg    <= in_pos_reg;
            if (pair_reg) begin
                dtot_reg   <= dtot_reg + DTOT_W'(d_reg);
                dsqsum_reg <= dsqsum_reg + SQSUM_W'(dsq_reg);
                nd_reg     <= nd_reg + 1'b1;
            end
        end else if (state_reg == ST_OUT && out_free) begin
            // Drop the series once its result is handed over
            count_reg       <= '0;
            sum_reg         <= '0;
            sqsum_reg       <= '0;
            prev_sample_reg <= '0;
            prev_pos_reg    <= '0;
            dtot_reg        <= '0;
            dsqsum_reg      <= '0;
            nd_reg          <= '0;
        end
    end

    // Store each step's result
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ISSUE) begin
            thr_auto_reg <= COUNT_W'(thr_prod[41:25]);
        end
        if (state_reg == ST_WAIT && arsp.done) begin
            case (step_reg)
                4'd0, 4'd4: p_reg <= product;
                4'd1, 4'd5: num_reg <= num_diff[WIDE_W] ? '0 : num_diff[WIDE_W-1:0];
                4'd2: den_reg <= product[DIVR_W-1:0];
                4'd3: var_reg <= (arsp.ovf || quotient[QUOT_W-1:32] != '0)
                                 ? '1 : quotient[31:0];
                4'd6: den_reg <= {product[DIVR_W-2:0], 1'b0};
                4'd7: noise_reg <= (arsp.ovf || quotient[QUOT_W-1] != 1'b0)
                                   ? '1 : quotient[32:0];
                4'd8: mean_reg <= (arsp.ovf || quotient[QUOT_W-1:16] != '0)
                                  ? '1 : quotient[15:0];
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {3'd0,
                            (nd_reg[COUNT_W-1] ? 20'hFFFFF : nd_reg[19:0]),
                            (nv ? noise_reg : 33'd0),
                            (sv ? var_reg : 32'd0),
                            ((count_reg != '0) ? mean_reg : 16'd0)};
            m_tuser_reg <= {nv, sv};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[verif/tb_gap_aware_noise_variance_unit.sv]
// Testbench for the gap-aware noise variance unit: random and directed series over the
// sample stream, checked against a built-in predictor of the series statistics.
// Depends on ganv_pkg and the RTL of gap_aware_noise_variance_unit.
`timescale 1ns / 1ps

module tb_gap_aware_noise_variance_unit
    import ganv_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 800;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [15:0] mean;
        logic [31:0] total_var;
        logic [32:0] noise_var;
        logic [19:0] diff_count;
        logic        stats_ok;
        logic        noise_ok;
    } series_stats_t;

    // Series statistics predictor and store of expected results
    class series_scoreboard;
        logic [15:0]   max_gap;
        logic [19:0]   min_count;
        logic          auto_thr;
        longint        count, sum, sq_sum, prev_sample, prev_pos, diff_sum, diff_sq, diffs;
        series_stats_t expected_q[$];
        int            errors, results, items;

        function new();
            max_gap = 0; min_count = 16; auto_thr = 1;
            errors = 0; results = 0; items = 0;
            clear();
        endfunction

        function void clear();
            count = 0; sum = 0; sq_sum = 0; prev_sample = 0; prev_pos = 0;
            diff_sum = 0; diff_sq = 0; diffs = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_MAX_GAP:  max_gap   = val[15:0];
                REG_MIN_DIFF: min_count = val[19:0];
                REG_AUTO_THR: auto_thr  = val[0];
                default: ;
            endcase
        endfunction

        // floor((a - b) / d), zero when a < b or d is zero
        function logic [127:0] spread_quot(logic [127:0] a, logic [127:0] b, logic [127:0] d);
            if (d == 0 || a < b) return 0;
            return (a - b) / d;
        endfunction

        // Note an accepted sample; push a result on the end of a series
        function void note_sample(logic [15:0] s, logic [30:0] pos, logic last);
            series_stats_t r;
            longint        thr, gap, d;
            logic [127:0]  q, ad;
            items++;
            if (count < MAX_SAMPLES) begin
                if (count > 0) begin
                    gap = longint'(pos) - prev_pos - 1;
                    if (gap <= longint'(max_gap)) begin
                        d = longint'(s) - prev_sample;
                        diff_sum += d;
                        diff_sq  += d * d;
                        diffs++;
                    end
                end
                count++;
                sum    += s;
                sq_sum += longint'(s) * s;
                prev_sample = s;
                prev_pos    = pos;
            end
            if (!last) return;
            thr = auto_thr ? ((count / 20 > 16) ? count / 20 : 16) : longint'(min_count);
            r.stats_ok = count >= 2;
            r.noise_ok = diffs >= thr && diffs >= 2;
            q = (count > 0) ? 128'(sum / count) : 0;
            r.mean = (q > 128'hFFFF) ? 16'hFFFF : q[15:0];
            q = r.stats_ok ? spread_quot(128'(count) * 128'(sq_sum), 128'(sum) * 128'(sum),
                                         128'(count) * 128'(count - 1)) : 0;
            r.total_var = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            ad = (diff_sum < 0) ? 128'(-diff_sum) : 128'(diff_sum);
            q = r.noise_ok ? spread_quot(128'(diffs) * 128'(diff_sq), ad * ad,
                                         128'(2 * diffs * (diffs - 1))) : 0;
            r.noise_var = (q > 128'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : q[32:0];
            r.diff_count = (diffs > 64'hFFFFF) ? 20'hFFFFF : diffs[19:0];
            expected_q.push_back(r);
            clear();
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_result(logic [103:0] data, logic [1:0] user);
            series_stats_t e;
            results++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result data=%h user=%b", $time, data, user);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (data[15:0] !== e.mean) begin
                $display("%0t: mean exp %h got %h", $time, e.mean, data[15:0]);
                errors++;
            end
            if (data[47:16] !== e.total_var) begin
                $display("%0t: total var exp %h got %h", $time, e.total_var, data[47:16]);
                errors++;
            end
            if (data[80:48] !== e.noise_var) begin
                $display("%0t: noise var exp %h got %h", $time, e.noise_var, data[80:48]);
                errors++;
            end
            if (data[100:81] !== e.diff_count) begin
                $display("%0t: diff count exp %h got %h", $time, e.diff_count, data[100:81]);
                errors++;
            end
            if (user[0] !== e.stats_ok) begin
                $display("%0t: stats_valid exp %b got %b", $time, e.stats_ok, user[0]);
                errors++;
            end
            if (user[1] !== e.noise_ok) begin
                $display("%0t: noise_valid exp %b got %b", $time, e.noise_ok, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic          aclk, aresetn;
    logic          psel, penable, pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata, prdata;
    logic          pready;
    logic          s_tvalid, s_tready, s_tlast;
    logic [47:0]   s_tdata;   // sample [15:0], position [46:16], zero pad
    logic          m_tvalid, m_tready;
    logic [103:0]  m_tdata;   // mean [15:0], total var [47:16], noise var [80:48],
                              // diff count [100:81], pad
    logic [1:0]    m_tuser;   // stats_valid [0], noise_valid [1]

    series_scoreboard sb;
    idle_mode_t       idle_mode;
    int               stall_cycles, series_sent;
    logic [30:0]      cur_pos;

    gap_aware_noise_variance_unit u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Drive the result side, check results and watch for a hang
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (idle_mode == IDLE_RECEIVER)
            m_tready <= ($urandom_range(99) >= 77);
        else if (idle_mode == IDLE_BOTH)
            m_tready <= ($urandom_range(99) >= 24);
        else
            m_tready <= 1'b1;
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, val);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Send one sample, idling first as the phase asks
    task automatic send_sample(logic [15:0] s, logic [30:0] pos, logic last);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SENDER) ? 77 : (idle_mode == IDLE_BOTH) ? 24 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, s};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(s, pos, last);
        if (last) series_sent++;
    endtask

    // Hold the sender until every result is back and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One random series: mostly a smooth signal with noise on nearby positions
    task automatic send_series();
        int          len, spread, i;
        logic [15:0] base, s;
        logic [30:0] step;
        case ($urandom_range(19))
            0:       len = 1;
            1:       len = $urandom_range(340, 420);
            2, 3:    len = 2;
            default: len = $urandom_range(3, 45);
        endcase
        base   = 16'($urandom);
        spread = (1 << $urandom_range(16));
        if ($urandom_range(9) == 0) cur_pos = 31'($urandom);
        for (i = 0; i < len; i++) begin
            case ($urandom_range(15))
                0:       s = 16'($urandom);
                1:       s = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: s = base + 16'($urandom_range(spread - 1));
            endcase
            case ($urandom_range(15))
                0:       step = 31'($urandom);
                1:       step = -31'($urandom_range(1, 4));
                2, 3:    step = 31'(sb.max_gap) + 31'($urandom_range(1, 2));
                4:       step = 31'(sb.max_gap) + 31'd1;
                default: step = 31'($urandom_range(1, 2));
            endcase
            cur_pos = cur_pos + step;
            send_sample(s, cur_pos, i == len - 1);
        end
    endtask

    initial begin
        logic [15:0] gaps [8]  = '{16'd0, 16'd65535, 16'd3, 16'd7, 16'd1, 16'd0, 16'd2, 16'd65535};
        logic [19:0] mins [8]  = '{20'd0, 20'd0, 20'hFFFFF, 20'd2, 20'd16, 20'd3, 20'd1, 20'd17};
        logic        autos [8] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        int          ph, sent_at_start, i;

        sb = new();
        idle_mode = IDLE_NONE;
        stall_cycles = 0; series_sent = 0; cur_pos = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0; s_tlast = 0; m_tready = 1;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single-sample series at the field extremes
        send_sample(16'h0000, 31'h0, 1'b1);
        send_sample(16'hFFFF, 31'h7FFF_FFFF, 1'b1);
        // Alternating extremes, backwards position, a gap, then a series long enough for noise
        send_sample(16'h0000, 31'd0, 1'b0);
        send_sample(16'hFFFF, 31'd1, 1'b0);
        send_sample(16'h0000, 31'd2, 1'b0);
        send_sample(16'hFFFF, 31'd1, 1'b0);
        send_sample(16'd100,  31'd5, 1'b0);
        send_sample(16'hFFFF, 31'd6, 1'b1);
        for (i = 0; i < 18; i++)
            send_sample(16'h8000 ^ 16'(i * 4099), 31'h7FFF_FFF0 + 31'(i), i == 17);
        drain();

        // Random phases, each with its own register setting and idling pattern
        for (ph = 0; ph < 8; ph++) begin
            apb_write(REG_MAX_GAP, {16'h0, gaps[ph]});
            apb_write(REG_MIN_DIFF, {12'h0, mins[ph]});
            apb_write(REG_AUTO_THR, {31'h0, autos[ph]});
            idle_mode = idle_mode_t'(ph % 4);
            sent_at_start = sb.items;
            while (sb.items - sent_at_start < 75)
                send_series();
            drain();
        end
        idle_mode = IDLE_NONE;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d samples in %0d series over 8 register settings and 4 idling modes;",
                 sb.items, series_sent);
        $display("%0d results checked, %0d mismatches.", sb.results, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
